### rtl/cbat_pkg.sv
package cbat_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned TotW = 40;
  localparam int unsigned EntryW = KeyW + TotW;

  localparam logic [63:0] HASH_SEED = 64'd7;
  localparam logic [63:0] HASH_MULT = 64'h4372_8978_9342_8797;
  localparam logic [40:0] TOTAL_LIMIT = 41'd1_000_000_000_000;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_FULL      = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  // Key of the frame 1,0,0,... padded to the hashed length.
  function automatic logic [63:0] fallback_key(int unsigned len);
    logic [63:0] h;
    h = HASH_SEED * HASH_MULT + 64'd1;
    for (int unsigned i = 1; i < len; i++) begin
      h = h * HASH_MULT;
    end
    return h;
  endfunction

endpackage

### rtl/cbat_ram.sv
module cbat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/cbat_mul.sv
module cbat_mul
  import cbat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  // Low 64 bits of a * HASH_MULT from three 32x32 partial products, one per cycle.
  logic        run_q;
  logic [1:0]  cnt_q;
  logic        done_q;
  logic [63:0] a_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [31:0] op_a;
  logic [31:0] op_b;

  always_comb begin
    case (cnt_q)
      2'd0: begin
        op_a = a_q[31:0];
        op_b = HASH_MULT[31:0];
      end
      2'd1: begin
        op_a = a_q[31:0];
        op_b = HASH_MULT[63:32];
      end
      default: begin
        op_a = a_q[63:32];
        op_b = HASH_MULT[31:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 2'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    if (run_q) begin
      prod_q <= {32'd0, op_a} * {32'd0, op_b};
      case (cnt_q)
        2'd1:    acc_q <= prod_q;
        2'd2:    acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
        2'd3:    acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

### rtl/call_site_byte_accounting_table.sv
// Live byte accounting per call site in an open-addressed hash table.
// An item is taken when start_i is high while busy_o is low. cmd_i selects
// a frame address beat, an allocation that ends the frame, a release from a
// slot or a read of a slot. A frame beat gives no result; the other commands
// each give one result, shown on the result ports for one cycle with done_o
// high. The receiver cannot stall, so results are never held back.
// A frame beat runs once through the shared 64-bit multiplier. An
// allocation runs it once per missing frame word to pad the hash, then forms
// a serial remainder over the 64 key bits when TABLE_SIZE is not a power of
// two, then probes the table memory slot by slot (read, then compare and
// write back). Release and read read the slot, then check it, and a release
// writes the new total back. The next item is taken in the cycle the result
// is shown. After reset the table memory is cleared one entry a cycle, with
// busy_o held high until every entry is cleared.
module call_site_byte_accounting_table
  import cbat_pkg::*;
#(
  parameter int TABLE_SIZE    = 4096,
  parameter int HASHED_LENGTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] frame_addr_i,
  input  logic [31:0] byte_count_i,
  input  logic [11:0] slot_in_i,
  output logic        done_o,
  output logic [11:0] slot_out_o,
  output logic [39:0] live_bytes_o,
  output logic [63:0] key_hash_o,
  output logic        used_fallback_o,
  output logic [1:0]  error_o
);

  localparam int SlotW = $clog2(TABLE_SIZE);
  localparam int UsedW = $clog2(TABLE_SIZE + 1);
  localparam int WordW = $clog2(HASHED_LENGTH + 1);
  localparam bit Pow2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [63:0] FbKey = fallback_key(HASHED_LENGTH);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_FRAME    = 10'b00_0000_0100,
    S_PAD      = 10'b00_0000_1000,
    S_KEY      = 10'b00_0001_0000,
    S_MOD      = 10'b00_0010_0000,
    S_PRB_RD   = 10'b00_0100_0000,
    S_PRB_CHK  = 10'b00_1000_0000,
    S_SLOT_RD  = 10'b01_0000_0000,
    S_SLOT_CHK = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [63:0] hash_q, hash_d;
  logic [WordW-1:0] words_q, words_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [SlotW-1:0] pos_q, pos_d;
  logic [SlotW-1:0] n_q, n_d;
  logic [SlotW-1:0] rem_q, rem_d;
  logic [5:0] bit_q, bit_d;
  logic mul_run_q, mul_run_d;
  logic [63:0] key_q, key_d;
  logic fb_q, fb_d;
  cmd_e cmd_q;
  logic [63:0] addr_q;
  logic [31:0] bytes_q;
  logic [11:0] slot_q;

  logic done_q, done_d;
  logic [11:0] res_slot_q, res_slot_d;
  logic [39:0] res_tot_q, res_tot_d;
  logic [63:0] res_key_q, res_key_d;
  logic res_fb_q, res_fb_d;
  logic [1:0] res_err_q, res_err_d;

  logic accept;
  logic mul_start;
  logic mul_done;
  logic [63:0] mul_p;

  logic ram_we;
  logic [SlotW-1:0] ram_addr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  logic [63:0] rd_key;
  logic [39:0] rd_tot;

  logic [SlotW:0] rem_shift;
  logic [SlotW:0] rem_next;
  logic [40:0] add_sum;
  logic over_half;
  logic below_fill;
  logic slot_in_rng;
  logic [39:0] slot_tot;

  assign busy_o = state_q != S_IDLE;
  assign accept = start_i && !busy_o;

  assign rd_key = ram_rdata[EntryW-1 -: KeyW];
  assign rd_tot = ram_rdata[TotW-1:0];

  assign rem_shift = {rem_q, key_q[bit_q]};
  assign rem_next  = (rem_shift >= (SlotW + 1)'(TABLE_SIZE)) ?
                     rem_shift - (SlotW + 1)'(TABLE_SIZE) : rem_shift;

  assign add_sum    = {1'b0, rd_tot} + {9'd0, bytes_q};
  assign over_half  = 32'(used_q) > 32'(TABLE_SIZE / 2);
  assign below_fill = (64'(used_q) * 64'd10) < (64'(TABLE_SIZE) * 64'd7);

  assign slot_in_rng = 32'(slot_q) < 32'(TABLE_SIZE);
  assign slot_tot    = slot_in_rng ? rd_tot : 40'd0;

  assign ram_addr = (state_q == S_SLOT_RD || state_q == S_SLOT_CHK) ?
                    SlotW'(slot_q) : pos_q;

  always_comb begin
    state_d    = state_q;
    hash_d     = hash_q;
    words_d    = words_q;
    used_d     = used_q;
    pos_d      = pos_q;
    n_d        = n_q;
    rem_d      = rem_q;
    bit_d      = bit_q;
    mul_run_d  = mul_run_q;
    key_d      = key_q;
    fb_d       = fb_q;
    mul_start  = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    done_d     = 1'b0;
    res_slot_d = res_slot_q;
    res_tot_d  = res_tot_q;
    res_key_d  = res_key_q;
    res_fb_d   = res_fb_q;
    res_err_d  = res_err_q;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        pos_d  = pos_q + SlotW'(1);
        if (pos_q == SlotW'(TABLE_SIZE - 1)) begin
          pos_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_FRAME: begin
              // Words beyond the hashed length are dropped.
              if (32'(words_q) < 32'(HASHED_LENGTH)) begin
                mul_start = 1'b1;
                state_d   = S_FRAME;
              end
            end
            CMD_ALLOC: begin
              mul_run_d = 1'b0;
              state_d   = S_PAD;
            end
            default: begin
              state_d = S_SLOT_RD;
            end
          endcase
        end
      end

      S_FRAME: begin
        if (mul_done) begin
          hash_d  = mul_p + addr_q;
          words_d = words_q + WordW'(1);
          state_d = S_IDLE;
        end
      end

      S_PAD: begin
        if (!mul_run_q) begin
          if (32'(words_q) < 32'(HASHED_LENGTH)) begin
            mul_start = 1'b1;
            mul_run_d = 1'b1;
          end else begin
            key_d   = hash_q;
            hash_d  = HASH_SEED;
            words_d = '0;
            fb_d    = 1'b0;
            state_d = S_KEY;
          end
        end else if (mul_done) begin
          hash_d    = mul_p;
          words_d   = words_q + WordW'(1);
          mul_run_d = 1'b0;
        end
      end

      S_KEY: begin
        n_d = '0;
        if (key_q == 64'd0) begin
          if (fb_q) begin
            done_d     = 1'b1;
            res_slot_d = '0;
            res_tot_d  = '0;
            res_key_d  = key_q;
            res_fb_d   = 1'b1;
            res_err_d  = ERR_FULL;
            state_d    = S_IDLE;
          end else begin
            key_d = FbKey;
            fb_d  = 1'b1;
          end
        end else if (Pow2) begin
          pos_d   = key_q[SlotW-1:0];
          state_d = S_PRB_RD;
        end else begin
          rem_d   = '0;
          bit_d   = 6'd63;
          state_d = S_MOD;
        end
      end

      S_MOD: begin
        rem_d = rem_next[SlotW-1:0];
        bit_d = bit_q - 6'd1;
        if (bit_q == 6'd0) begin
          pos_d   = rem_next[SlotW-1:0];
          state_d = S_PRB_RD;
        end
      end

      S_PRB_RD: begin
        state_d = S_PRB_CHK;
      end

      S_PRB_CHK: begin
        if (rd_key == 64'd0 && over_half && !fb_q) begin
          key_d   = FbKey;
          fb_d    = 1'b1;
          state_d = S_KEY;
        end else if (rd_key == 64'd0 || rd_key == key_q) begin
          done_d     = 1'b1;
          res_slot_d = 12'(pos_q);
          res_key_d  = key_q;
          res_fb_d   = fb_q;
          state_d    = S_IDLE;
          if (rd_key == 64'd0 && over_half && !below_fill) begin
            res_slot_d = '0;
            res_tot_d  = '0;
            res_err_d  = ERR_FULL;
          end else begin
            ram_we = 1'b1;
            if (rd_key == 64'd0) begin
              used_d = used_q + UsedW'(1);
            end
            // The key is claimed even when the total would overflow.
            if (add_sum >= TOTAL_LIMIT) begin
              ram_wdata = {key_q, rd_tot};
              res_tot_d = rd_tot;
              res_err_d = ERR_OVERFLOW;
            end else begin
              ram_wdata = {key_q, add_sum[39:0]};
              res_tot_d = add_sum[39:0];
              res_err_d = ERR_OK;
            end
          end
        end else if (n_q == SlotW'(TABLE_SIZE - 1)) begin
          done_d     = 1'b1;
          res_slot_d = '0;
          res_tot_d  = '0;
          res_key_d  = key_q;
          res_fb_d   = fb_q;
          res_err_d  = ERR_FULL;
          state_d    = S_IDLE;
        end else begin
          n_d     = n_q + SlotW'(1);
          pos_d   = (pos_q == SlotW'(TABLE_SIZE - 1)) ? '0 : pos_q + SlotW'(1);
          state_d = S_PRB_RD;
        end
      end

      S_SLOT_RD: begin
        state_d = S_SLOT_CHK;
      end

      S_SLOT_CHK: begin
        done_d     = 1'b1;
        res_slot_d = slot_q;
        res_key_d  = slot_in_rng ? rd_key : 64'd0;
        res_fb_d   = 1'b0;
        res_tot_d  = slot_tot;
        res_err_d  = ERR_OK;
        state_d    = S_IDLE;
        if (cmd_q == CMD_FREE) begin
          if (40'(bytes_q) > slot_tot) begin
            res_err_d = ERR_UNDERFLOW;
          end else begin
            res_tot_d = slot_tot - 40'(bytes_q);
            if (slot_in_rng) begin
              ram_we    = 1'b1;
              ram_wdata = {rd_key, slot_tot - 40'(bytes_q)};
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      hash_q    <= HASH_SEED;
      words_q   <= '0;
      used_q    <= '0;
      pos_q     <= '0;
      mul_run_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      hash_q    <= hash_d;
      words_q   <= words_d;
      used_q    <= used_d;
      pos_q     <= pos_d;
      mul_run_q <= mul_run_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    rem_q      <= rem_d;
    bit_q      <= bit_d;
    key_q      <= key_d;
    fb_q       <= fb_d;
    res_slot_q <= res_slot_d;
    res_tot_q  <= res_tot_d;
    res_key_q  <= res_key_d;
    res_fb_q   <= res_fb_d;
    res_err_q  <= res_err_d;
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      addr_q  <= frame_addr_i;
      bytes_q <= byte_count_i;
      slot_q  <= slot_in_i;
    end
  end

  cbat_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (hash_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  cbat_ram #(
    .Width (EntryW),
    .Depth (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign done_o          = done_q;
  assign slot_out_o      = res_slot_q;
  assign live_bytes_o    = res_tot_q;
  assign key_hash_o      = res_key_q;
  assign used_fallback_o = res_fb_q;
  assign error_o         = res_err_q;

endmodule
